FILE: src/wsd_pkg.sv
package wsd_pkg;

   localparam int LEN_BITS = 32;

   localparam logic [7:0] OP_TEXT   = 8'h81;
   localparam logic [7:0] OP_BINARY = 8'h82;
   localparam logic [7:0] LEN7_MASK = 8'h7f;
   localparam logic [7:0] LEN_EXT16 = 8'd126;
   localparam logic [7:0] LEN_EXT64 = 8'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       is_binary;
   } result_type;

endpackage

FILE: src/wsd_in_stage.sv
module wsd_in_stage
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

FILE: src/wsd_parser.sv
module wsd_parser
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_LEN     = 3'd1,
      PH_EXT     = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [3:0]          ext_left_ff, ext_left_in;
   logic [LEN_BITS-1:0] payload_left_ff, payload_left_in;
   logic [31:0]         mask_key_ff, mask_key_in;
   logic [1:0]          mask_index_ff, mask_index_in;
   logic                binary_flag_ff, binary_flag_in;

   logic [7:0]          len7;
   logic [7:0]          key;
   logic [LEN_BITS-1:0] left_dec;

   assign len7     = rx_byte & LEN7_MASK;
   assign key      = 8'(mask_key_ff >> {mask_index_ff, 3'b000});
   assign left_dec = payload_left_ff - LEN_BITS'(1);

   always_comb begin
      phase_in        = phase_ff;
      ext_left_in     = ext_left_ff;
      payload_left_in = payload_left_ff;
      mask_key_in     = mask_key_ff;
      mask_index_in   = mask_index_ff;
      binary_flag_in  = binary_flag_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (len7 == LEN_EXT16) begin
                  ext_left_in     = EXT16_BYTES;
                  payload_left_in = '0;
                  phase_in        = PH_EXT;
               end else if (len7 == LEN_EXT64) begin
                  ext_left_in     = EXT64_BYTES;
                  payload_left_in = '0;
                  phase_in        = PH_EXT;
               end else begin
                  ext_left_in     = '0;
                  payload_left_in = LEN_BITS'(len7);
                  mask_index_in   = '0;
                  phase_in        = PH_MASK;
               end
            end
            PH_EXT: begin
               payload_left_in = {payload_left_ff[LEN_BITS-9:0], rx_byte};
               ext_left_in     = ext_left_ff - 4'd1;
               if (ext_left_ff == 4'd1) begin
                  mask_index_in = '0;
                  phase_in      = PH_MASK;
               end
            end
            PH_MASK: begin
               mask_key_in   = mask_key_ff | (32'(rx_byte) << {mask_index_ff, 3'b000});
               mask_index_in = mask_index_ff + 2'd1;
               if (mask_index_ff == 2'd3) begin
                  if (payload_left_ff == '0) begin
                     phase_in      = PH_FIRST;
                     res_valid     = 1'b1;
                     res.kind      = KIND_EMPTY;
                     res.is_binary = binary_flag_ff;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               mask_index_in   = mask_index_ff + 2'd1;
               payload_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_FIRST;
               end
               res_valid     = 1'b1;
               res.kind      = KIND_PAYLOAD;
               res.data      = rx_byte ^ key;
               res.last      = (left_dec == '0);
               res.is_binary = binary_flag_ff;
            end
            default: begin
               if (rx_byte == OP_TEXT || rx_byte == OP_BINARY) begin
                  binary_flag_in  = (rx_byte == OP_BINARY);
                  ext_left_in     = '0;
                  payload_left_in = '0;
                  mask_key_in     = '0;
                  mask_index_in   = '0;
                  phase_in        = PH_LEN;
               end else begin
                  phase_in  = PH_FIRST;
                  res_valid = 1'b1;
                  res.kind  = KIND_BAD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_FIRST;
         ext_left_ff     <= '0;
         payload_left_ff <= '0;
         mask_key_ff     <= '0;
         mask_index_ff   <= '0;
         binary_flag_ff  <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         ext_left_ff     <= ext_left_in;
         payload_left_ff <= payload_left_in;
         mask_key_ff     <= mask_key_in;
         mask_index_ff   <= mask_index_in;
         binary_flag_ff  <= binary_flag_in;
      end
   end

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> payload_left_ff != '0)
      else $error("payload phase with no bytes left");

   a_ext_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_EXT |-> ext_left_ff != '0)
      else $error("extended length phase with no bytes left");

   a_len_clears_key: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LEN |-> mask_key_ff == '0 && mask_index_ff == '0)
      else $error("mask key not cleared at frame start");

endmodule

FILE: src/wsd_rsp_stage.sv
module wsd_rsp_stage
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       advance,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic [2:0] rsp_tuser
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign advance  = !valid_ff || rsp_tready;
   assign valid_in = advance ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.data;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tuser  = {res_ff.is_binary, res_ff.kind};

endmodule

FILE: src/websocket_frame_deframer.sv
// WebSocket deframer: takes one received byte per word on req_ and returns unmasked
// payload bytes on rsp_, one byte per cycle sustained while rsp_tready is held high; each
// byte passes an input register and then a result register before its result is
// presented on rsp_.
// Frames must open with 0x81 (text) or 0x82 (binary); anything else gives a bad-first-byte
// word and the next byte is again taken as a frame opener. Header, extended length and
// mask key bytes give no word; a zero-length frame gives one empty-frame word. Lengths are
// held to LEN_BITS bits (a 64-bit length keeps its low bits). rsp_tuser[1:0] is the kind
// (0 payload, 1 empty frame, 2 bad first byte), rsp_tuser[2] marks a binary frame.
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // data
   output logic       rsp_tlast,
   output logic [2:0] rsp_tuser    // kind[1:0], is_binary[2]
);

   logic       advance;
   logic       byte_valid;
   logic [7:0] byte_data;
   logic       res_valid;
   result_type res;

   wsd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (byte_valid && advance),
      .rx_byte   (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_non_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != KIND_PAYLOAD |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("non-payload word carries data or last");

   a_bad_not_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_BAD |-> !rsp_tuser[2])
      else $error("bad first byte word marked binary");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] == KIND_PAYLOAD || rsp_tuser[1:0] == KIND_EMPTY
                     || rsp_tuser[1:0] == KIND_BAD)
      else $error("unknown result kind");

endmodule
